// ===== rtl/core/hann_grain_windower_with_peak_meter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Hann grain windower
// Shared property forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HANN_GRAIN_WINDOWER_WITH_PEAK_METER_UNIT_MACROS_SVH
`define HANN_GRAIN_WINDOWER_WITH_PEAK_METER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HGW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HGW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hgw_pkg.sv =====
// ----------------------------------------------------------------------------
// hgw_pkg
// Types, constants and step codes for the Hann grain windower.
// ----------------------------------------------------------------------------
`default_nettype none

package hgw_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned QUOT_W        = 32;
  localparam int unsigned DIV_BITS      = 2;
  localparam int unsigned DIV_STEPS     = QUOT_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [31:0] Q30_ONE       = 32'h4000_0000;
  localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;
  localparam logic [32:0] ROUND_Q15     = 33'd16384;
  localparam logic [15:0] W_ONE         = 16'h8000;

  // Odd Taylor coefficients of sin(pi/2 * u), Q2.30
  localparam logic [31:0] SIN_C1        = 32'd1686629713;
  localparam logic [31:0] SIN_C3        = 32'd693598668;
  localparam logic [31:0] SIN_C5        = 32'd85569306;
  localparam logic [31:0] SIN_C7        = 32'd5026995;
  localparam logic [31:0] SIN_C9        = 32'd172271;
  localparam logic [31:0] SIN_C11       = 32'd3864;

  // Multiply sequence
  localparam logic [3:0] STEP_U2      = 4'd0;
  localparam logic [3:0] STEP_H9      = 4'd1;
  localparam logic [3:0] STEP_H7      = 4'd2;
  localparam logic [3:0] STEP_H5      = 4'd3;
  localparam logic [3:0] STEP_H3      = 4'd4;
  localparam logic [3:0] STEP_H1      = 4'd5;
  localparam logic [3:0] STEP_SIN     = 4'd6;
  localparam logic [3:0] STEP_SQ      = 4'd7;
  localparam logic [3:0] STEP_APPLY_L = 4'd8;
  localparam logic [3:0] STEP_APPLY_R = 4'd9;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] num;
    logic [SAMPLE_W-1:0] den;
  } hgw_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } hgw_div_rsp_t;

  // Constant from which the product is subtracted in each Horner step
  function automatic logic [31:0] hgw_horner_coef(input logic [3:0] step);
    logic [31:0] c;
    unique case (step)
      STEP_H9: c = SIN_C9;
      STEP_H7: c = SIN_C7;
      STEP_H5: c = SIN_C5;
      STEP_H3: c = SIN_C3;
      STEP_H1: c = SIN_C1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hann_grain_windower_with_peak_meter_unit.sv =====
// ----------------------------------------------------------------------------
// hann_grain_windower_with_peak_meter_unit
// Stereo Hann grain windower with per-channel peak meter.
// ----------------------------------------------------------------------------
// Flow: a windowed word passes through the phase divider, a handoff into the
//   multiply state, 10 multiplies (issue, then write back) on one shared
//   multiplier and an output load; pass-through or short words go straight to the load.
// A new word is accepted only after the last one is loaded, which waits on out_ready_i;
//   the pace is set by the shared multiplier and the 2-bit-per-cycle phase divider.
// Reset (async, active low): grain length, grain position and peaks are 0.
// ----------------------------------------------------------------------------
`default_nettype none

module hann_grain_windower_with_peak_meter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [15:0] left_sample_i,
  input  wire logic signed [15:0] right_sample_i,
  input  wire logic        new_grain_i,
  input  wire logic        chunk_start_i,
  // output words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_right_o,
  output logic             grain_active_o,
  output logic      [15:0] peak_left_o,
  output logic      [15:0] peak_right_o
);
  import hgw_pkg::*;

`include "hann_grain_windower_with_peak_meter_unit_macros.svh"

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  logic [1:0]  state_q, state_d;
  logic [15:0] len_q, len_d;          // grain length N
  logic [15:0] pos_q, pos_d;          // grain position n
  logic [15:0] peak_l_q, peak_l_d;
  logic [15:0] peak_r_q, peak_r_d;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  step_q, step_d;        // multiply step
  logic        phase_q, phase_d;      // 0: issue, 1: write back

  // Payload (no reset)
  logic signed [15:0] x_l_q, x_r_q;   // captured samples
  logic signed [15:0] res_l_q, res_r_q;
  logic        active_q;
  logic [30:0] u_q;                   // folded phase, Q1.30 in [0,1]
  logic [30:0] u2_q;
  logic [31:0] acc_q;                 // Horner term, then sin
  logic [15:0] w_q;                   // Q1.15 weight
  logic signed [15:0] out_l_q, out_r_q;
  logic        out_act_q;
  logic [15:0] out_pk_l_q, out_pk_r_q;

  // --------------------------------------------------------------------------
  // Accept-side logic
  // --------------------------------------------------------------------------
  logic        accept;
  logic [15:0] pos_eff;
  logic        active_now;
  logic        short_grain;
  logic [15:0] abs_l, abs_r;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign pos_eff     = new_grain_i ? 16'd0 : pos_q;
  assign active_now  = (pos_eff < len_q);
  assign short_grain = (len_q <= 16'd1);

  // |x| as unsigned; the most negative sample maps to 32768
  assign abs_l = left_sample_i[15]  ? 16'(~left_sample_i + 16'sd1)  : left_sample_i;
  assign abs_r = right_sample_i[15] ? 16'(~right_sample_i + 16'sd1) : right_sample_i;

  // --------------------------------------------------------------------------
  // Phase divider: n * 2^32 / (N - 1)
  // --------------------------------------------------------------------------
  hgw_div_req_t div_req;
  hgw_div_rsp_t div_rsp;

  assign div_req.start = accept && active_now && !short_grain;
  assign div_req.num   = pos_eff;
  assign div_req.den   = len_q - 16'd1;

  hgw_phase_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // fold the second half of the turn back: weight is symmetric
  logic [31:0] ph_fold;
  assign ph_fold = (div_rsp.quot > PHASE_HALF) ? (~div_rsp.quot + 32'd1) : div_rsp.quot;

  // --------------------------------------------------------------------------
  // Shared multiplier and operand select
  // --------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [63:0] prod;
  logic [15:0] mag_l, mag_r;

  assign mag_l  = x_l_q[15] ? 16'(~x_l_q + 16'sd1) : x_l_q;
  assign mag_r  = x_r_q[15] ? 16'(~x_r_q + 16'sd1) : x_r_q;
  assign mul_en = (state_q == ST_MUL) && !phase_q;

  always_comb begin
    case (step_q) inside
      STEP_U2: begin
        mul_a = {1'b0, u_q};
        mul_b = {1'b0, u_q};
      end
      STEP_H9: begin
        mul_a = {1'b0, u2_q};
        mul_b = SIN_C11;
      end
      STEP_H7, STEP_H5, STEP_H3, STEP_H1: begin
        mul_a = {1'b0, u2_q};
        mul_b = acc_q;
      end
      STEP_SIN: begin
        mul_a = {1'b0, u_q};
        mul_b = acc_q;
      end
      STEP_SQ: begin
        mul_a = acc_q;
        mul_b = acc_q;
      end
      STEP_APPLY_L: begin
        mul_a = {16'd0, mag_l};
        mul_b = {16'd0, w_q};
      end
      STEP_APPLY_R: begin
        mul_a = {16'd0, mag_r};
        mul_b = {16'd0, w_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hgw_mul_unit u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Q30 product, rounding of sin^2 into Q1.15
  logic [33:0] prod_q30;
  logic [32:0] w_sum;
  logic [17:0] w_raw;
  logic [15:0] p_q15;

  assign prod_q30 = prod[63:30];
  assign w_sum    = {1'b0, prod_q30[31:0]} + ROUND_Q15;
  assign w_raw    = w_sum[32:15];
  assign p_q15    = prod[30:15];

  logic wb;
  assign wb = (state_q == ST_MUL) && phase_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic load_out;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    len_d       = cfg_we_i ? cfg_data_i : len_q;
    pos_d       = pos_q;
    peak_l_d    = peak_l_q;
    peak_r_d    = peak_r_q;
    step_d      = step_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // peaks: clear on chunk start, then take this pair
          peak_l_d = chunk_start_i ? abs_l : ((abs_l > peak_l_q) ? abs_l : peak_l_q);
          peak_r_d = chunk_start_i ? abs_r : ((abs_r > peak_r_q) ? abs_r : peak_r_q);
          pos_d    = active_now ? pos_eff + 16'd1 : pos_eff;
          if (active_now && !short_grain) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_MUL;
          step_d  = STEP_U2;
          phase_d = 1'b0;
        end
      end
      ST_MUL: begin
        phase_d = !phase_q;
        if (phase_q) begin
          if (step_q == STEP_APPLY_R) begin
            state_d = ST_DONE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      pos_q       <= '0;
      peak_l_q    <= '0;
      peak_r_q    <= '0;
      step_q      <= STEP_U2;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      peak_l_q    <= peak_l_d;
      peak_r_q    <= peak_r_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_l_q    <= left_sample_i;
      x_r_q    <= right_sample_i;
      active_q <= active_now;
      if (!active_now) begin
        // past the grain: pass through
        res_l_q <= left_sample_i;
        res_r_q <= right_sample_i;
      end else begin
        // N <= 1 gives zero weight; otherwise overwritten by the multiply steps
        res_l_q <= '0;
        res_r_q <= '0;
      end
    end

    if (state_q == ST_DIV && div_rsp.done) begin
      u_q <= ph_fold[31:1];
    end

    if (wb) begin
      case (step_q) inside
        STEP_U2: begin
          u2_q <= prod_q30[30:0];
        end
        STEP_H9, STEP_H7, STEP_H5, STEP_H3, STEP_H1: begin
          acc_q <= hgw_horner_coef(step_q) - prod_q30[31:0];
        end
        STEP_SIN: begin
          acc_q <= (prod_q30 > {2'b00, Q30_ONE}) ? Q30_ONE : prod_q30[31:0];
        end
        STEP_SQ: begin
          w_q <= (w_raw > {2'b00, W_ONE}) ? W_ONE : w_raw[15:0];
        end
        STEP_APPLY_L: begin
          // truncate magnitude toward zero, then restore sign
          res_l_q <= x_l_q[15] ? 16'(~p_q15 + 16'd1) : p_q15;
        end
        STEP_APPLY_R: begin
          res_r_q <= x_r_q[15] ? 16'(~p_q15 + 16'd1) : p_q15;
        end
        default: begin
        end
      endcase
    end

    if (load_out) begin
      out_l_q    <= res_l_q;
      out_r_q    <= res_r_q;
      out_act_q  <= active_q;
      out_pk_l_q <= peak_l_q;
      out_pk_r_q <= peak_r_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_left_o     = out_l_q;
  assign out_right_o    = out_r_q;
  assign grain_active_o = out_act_q;
  assign peak_left_o    = out_pk_l_q;
  assign peak_right_o   = out_pk_r_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HGW_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")
  `HGW_ASSERT_SAME(a_div_done_in_div, div_rsp.done, state_q == ST_DIV, "divider done outside DIV state")
  `HGW_ASSERT_SAME(a_weight_range, state_q == ST_MUL && step_q == STEP_APPLY_L, w_q <= W_ONE, "weight above one")

endmodule

`default_nettype wire

// ===== rtl/core/hgw_phase_div.sv =====
// ----------------------------------------------------------------------------
// hgw_phase_div
// Radix-4 restoring divider: floor(num * 2^32 / den) mod 2^32, num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module hgw_phase_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hgw_pkg::hgw_div_req_t req_i,
  output hgw_pkg::hgw_div_rsp_t     rsp_o
);
  import hgw_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SAMPLE_W-1:0]  rem_q;
  logic [SAMPLE_W-1:0]  den_q;
  logic [QUOT_W-1:0]    quot_q;

  logic [SAMPLE_W:0]    r1, r2;
  logic                 b1, b2;
  logic [SAMPLE_W-1:0]  r1n, r2n;

  // two quotient bits per cycle; dividend low bits are all zero
  always_comb begin
    r1  = {rem_q, 1'b0};
    b1  = (r1 >= {1'b0, den_q});
    r1n = b1 ? SAMPLE_W'(r1 - {1'b0, den_q}) : r1[SAMPLE_W-1:0];
    r2  = {r1n, 1'b0};
    b2  = (r2 >= {1'b0, den_q});
    r2n = b2 ? SAMPLE_W'(r2 - {1'b0, den_q}) : r2[SAMPLE_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // integer part of the quotient (one turn) is dropped
      rem_q  <= (req_i.num >= req_i.den) ? SAMPLE_W'(req_i.num - req_i.den) : req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= r2n;
      quot_q <= {quot_q[QUOT_W-3:0], b1, b2};
      cnt_q  <= cnt_q + DIV_CNT_W'(1);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/core/hgw_mul_unit.sv =====
// ----------------------------------------------------------------------------
// hgw_mul_unit
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module hgw_mul_unit (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {32'd0, a_i} * {32'd0, b_i};
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
